@@ src/skd_pkg.sv @@
// Shared types and constants for the sorted key dictionary.
`default_nettype none

package skd_pkg;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int ST_W    = 2;
  localparam int POS_W   = 7;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 120;

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PRED   = 3'd3,
    OP_SUCC   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_FULL         = 2'd2,
    ST_NO_NEIGHBOUR = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic update;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ src/skd_controller.sv @@
// Sequencer for one dictionary operation: capture, compare, update, output.
`default_nettype none

module skd_controller
  import skd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    COMPARE,
    UPDATE,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    s_tready    = (state == IDLE) && !rst;
    cmd         = '0;
    cmd.capture = s_tvalid && s_tready;
    cmd.compare = (state == COMPARE);
    cmd.update  = (state == UPDATE);
    cmd.load    = (state == FINISH) && stat.out_free;
    state_next  = state;
    unique case (state)
      IDLE:    if (s_tvalid) state_next = COMPARE;
      COMPARE: state_next = UPDATE;
      UPDATE:  state_next = FINISH;
      FINISH:  if (stat.out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ src/skd_datapath.sv @@
// Sorted key row with per-entry compare, shift update and result register.
`default_nettype none

module skd_datapath
  import skd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [OP_W-1:0]         op_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] cells      [CAPACITY];
  logic signed [KEY_W-1:0] cells_next [CAPACITY];
  logic signed [KEY_W-1:0] prev_key   [CAPACITY];
  logic signed [KEY_W-1:0] next_key   [CAPACITY];
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [CAPACITY-1:0]     lt_q;
  logic [CAPACITY-1:0]     eq_q;
  logic [CAPACITY-1:0]     bnd;
  logic [ST_W-1:0]         status_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [KEY_W-1:0] nb_q;

  logic                    found;
  logic                    full;
  logic                    at_last;
  logic [IW-1:0]           idx;
  logic [CW:0]             idx_plus;
  logic signed [KEY_W-1:0] pred_key;
  logic signed [KEY_W-1:0] succ_key;
  logic [ST_W-1:0]         status_d;
  logic [POS_W-1:0]        pos_d;
  logic signed [KEY_W-1:0] nb_d;
  logic                    do_insert;
  logic                    do_delete;
  logic                    empty;
  logic signed [KEY_W-1:0] min_d;
  logic signed [KEY_W-1:0] max_d;

  // boundary marks the lower-bound entry; neighbor taps per entry
  for (genvar j = 0; j < CAPACITY; j++) begin : g_row
    if (j == 0) begin : g_first
      assign bnd[j]      = !lt_q[j];
      assign prev_key[j] = key_q;
    end else begin : g_rest
      assign bnd[j]      = !lt_q[j] && lt_q[j-1];
      assign prev_key[j] = cells[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign next_key[j] = cells[j];
    end else begin : g_inner
      assign next_key[j] = cells[j+1];
    end
  end

  always_comb begin
    idx      = '0;
    pred_key = '0;
    succ_key = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (bnd[j]) idx = idx | IW'(j);
      if (j + 1 < CAPACITY && bnd[(j+1) % CAPACITY]) pred_key = pred_key | cells[j];
      if (j > 0 && bnd[(j+CAPACITY-1) % CAPACITY]) succ_key = succ_key | cells[j];
    end
  end

  assign found    = |(bnd & eq_q);
  assign full     = (count == CW'(CAPACITY));
  assign idx_plus = (CW+1)'(idx) + (CW+1)'(1);
  assign at_last  = (idx_plus >= (CW+1)'(count));

  always_comb begin
    status_d  = ST_OK;
    pos_d     = '0;
    nb_d      = '0;
    do_insert = 1'b0;
    do_delete = 1'b0;
    unique case (op_q)
      OP_FIND: begin
        if (found) pos_d = POS_W'(idx);
        else status_d = ST_NOT_FOUND;
      end
      OP_ADD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          pos_d     = POS_W'(idx);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          do_delete = 1'b1;
          pos_d     = POS_W'(idx);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_PRED: begin
        if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          pos_d = POS_W'(idx);
          if (idx == '0) status_d = ST_NO_NEIGHBOUR;
          else nb_d = pred_key;
        end
      end
      OP_SUCC: begin
        if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          pos_d = POS_W'(idx);
          if (at_last) status_d = ST_NO_NEIGHBOUR;
          else nb_d = succ_key;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_insert) count_next = count + CW'(1);
    else if (do_delete) count_next = count - CW'(1);
    for (int j = 0; j < CAPACITY; j++) begin
      cells_next[j] = cells[j];
      if (do_insert && !lt_q[j]) cells_next[j] = bnd[j] ? key_q : prev_key[j];
      if (do_delete && !lt_q[j]) cells_next[j] = next_key[j];
    end
  end

  always_comb begin
    empty = (count == '0);
    min_d = empty ? '0 : cells[0];
    max_d = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (count == CW'(j + 1)) max_d = max_d | cells[j];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= s_tdata[OP_W-1:0];
      key_q <= s_tdata[OP_W +: KEY_W];
    end
    if (cmd.compare) begin
      for (int j = 0; j < CAPACITY; j++) begin
        lt_q[j] <= (CW'(j) < count) && (cells[j] < key_q);
        eq_q[j] <= (CW'(j) < count) && (cells[j] == key_q);
      end
    end
    if (cmd.update) begin
      cells    <= cells_next;
      status_q <= status_d;
      pos_q    <= pos_d;
      nb_q     <= nb_d;
    end
    if (cmd.load) begin
      m_tdata <= {7'b0, empty, max_d, min_d, POS_W'(count), nb_q, pos_q, status_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.update) count <= count_next;
      if (cmd.load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (count == $past(count)) || (count == $past(count) + CW'(1))
                   || (count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_less_prefix: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (((lt_q >> 1) & ~lt_q) == '0))
    else $error("less-than flags not a prefix, row unsorted");

  a_one_boundary: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $onehot0(bnd))
    else $error("more than one lower-bound entry");

endmodule

`default_nettype wire

@@ src/sorted_key_dictionary.sv @@
// Top level of the sorted key dictionary: controller plus key row datapath.
//
//  channel   dir  fields (low bit first)
//  s_*       in   tdata: operation[2:0] key[34:3], zero pad to 40
//  m_*       out  tdata: status[1:0] position[8:2] neighbour_key[40:9]
//                        entry_count[47:41] min_key[79:48] max_key[111:80]
//                        table_empty[112], zero pad to 120
//
//  Each transaction steps: accept, compare all entries, shift/update, load the
//  result register. The next input is taken the cycle after the load.
//  A stalled output holds the controller in its final step until taken.
//  rst is synchronous; it empties the dictionary and drops any pending result.
`default_nettype none

module sorted_key_dictionary
  import skd_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // operation, key
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata    // status, position, neighbour_key,
                                            // entry_count, min_key, max_key,
                                            // table_empty
);

  cmd_t  cmd;
  stat_t stat;

  skd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skd_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
